/* rtl/core/rhsn_pkg.sv */
// shared types, codes and step functions for the ray hit surface normal pipeline
package rhsn_pkg;

  localparam logic [1:0] KIND_SPHERE   = 2'd0;
  localparam logic [1:0] KIND_PLANE    = 2'd1;
  localparam logic [1:0] KIND_CONE     = 2'd2;
  localparam logic [1:0] KIND_CYLINDER = 2'd3;

  // front stages, square root stages (two root bits each), divider stages
  // (two quotient bits each) and the output register
  localparam int N_PRE = 14;
  localparam int N_SQ  = 16;
  localparam int N_DV  = 8;
  localparam int N_ST  = N_PRE + N_SQ + N_DV + 1;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  // per item data that rides alongside the normalising datapath
  typedef struct packed {
    logic [2:0][20:0] hit;
    logic             plane;
    logic [2:0][15:0] pn;
    logic [2:0]       sgn;
    logic             zero;
  } side_t;

  // one digit of a restoring square root
  function automatic sq_t sqrt_step(sq_t s, logic [1:0] xb);
    sq_t         res;
    logic [34:0] rm;
    logic [34:0] tr;
    rm = {s.rem[32:0], xb};
    tr = {1'b0, s.root, 2'b01};
    if (rm >= tr) begin
      res.rem  = rm - tr;
      res.root = {s.root[30:0], 1'b1};
    end else begin
      res.rem  = rm;
      res.root = {s.root[30:0], 1'b0};
    end
    return res;
  endfunction

  // position of the highest set bit of a nine bit group
  function automatic logic [3:0] msb9(logic [8:0] v);
    logic [3:0] p;
    p = '0;
    for (int j = 0; j < 9; j++) begin
      if (v[j]) begin
        p = 4'(j);
      end
    end
    return p;
  endfunction

endpackage

/* rtl/core/ray_hit_surface_normal_core.sv */
// ray hit point and unit surface normal for sphere, plane, cone and cylinder
//
// Usage: one hit per transaction on the in_ channel (valid/stall), one result
// per transaction on the out_ channel. A transaction moves at a rising edge
// where valid is high and stall is low. Each hit gives the saturated hit point
// P = O + t*D in Q10.10 and a Q1.14 unit normal; a zero-length vector to
// normalise gives zero normal components with out_degenerate set.
// Throughput: one transaction per cycle, sustained while the output is not stalled.
// Depth: the pipeline runs from the input to the output register through the
// fourteen front stages (products, sums, axial projection, cone scaling,
// range normalisation, squares), sixteen square root stages resolving two
// root bits each and eight divider stages resolving two quotient bits each.
// Stall: the whole pipeline holds while the output register carries a result
// that the receiver stalls; in_stall is high exactly then, so nothing is lost
// or repeated. Bubbles in the pipeline are passed along as empty slots.
// Reset: rst_n low clears every stage valid bit at the next edge; the data
// registers are not reset.
module ray_hit_surface_normal_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [62:0]        in_ray_origin,
  input  logic [62:0]        in_ray_direction,
  input  logic [30:0]        in_hit_distance,
  input  logic [1:0]         in_shape_kind,
  input  logic [62:0]        in_shape_centre,
  input  logic [62:0]        in_shape_axis,
  input  logic [23:0]        in_cone_slope_sq,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic signed [20:0] out_hit_x,
  output logic signed [20:0] out_hit_y,
  output logic signed [20:0] out_hit_z,
  output logic               out_degenerate
);

  localparam int NST = rhsn_pkg::N_ST;
  localparam int NSQ = rhsn_pkg::N_SQ;
  localparam int NDV = rhsn_pkg::N_DV;

  logic           adv;
  logic [NST-1:0] v_r;

  assign adv       = !(v_r[NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1: unpack and form all first level products
  logic signed [20:0] o [3];
  logic signed [20:0] d [3];
  logic signed [20:0] c [3];
  logic signed [20:0] a [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o[i] = in_ray_origin[21*i +: 21];
      d[i] = in_ray_direction[21*i +: 21];
      c[i] = in_shape_centre[21*i +: 21];
      a[i] = in_shape_axis[21*i +: 21];
    end
  end

  logic signed [52:0] s1_td_r  [3];
  logic signed [42:0] s1_oca_r [3];
  logic signed [41:0] s1_da_r  [3];
  logic signed [20:0] s1_o_r   [3];
  logic signed [20:0] s1_c_r   [3];
  logic signed [20:0] s1_a_r   [3];
  logic [30:0]        s1_t_r;
  logic [1:0]         s1_kind_r;
  logic [23:0]        s1_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_td_r[i]  <= $signed({1'b0, in_hit_distance}) * d[i];
        s1_oca_r[i] <= (43'(o[i]) - 43'(c[i])) * 43'(a[i]);
        s1_da_r[i]  <= d[i] * a[i];
        s1_o_r[i]   <= o[i];
        s1_c_r[i]   <= c[i];
        s1_a_r[i]   <= a[i];
      end
      s1_t_r    <= in_hit_distance;
      s1_kind_r <= in_shape_kind;
      s1_k_r    <= in_cone_slope_sq;
    end
  end

  // stage 2: hit point with saturation, rounded dot products
  logic signed [37:0] s2_tdr [3];
  logic signed [38:0] s2_ps  [3];
  logic signed [20:0] s2_p   [3];
  logic signed [44:0] s2_doa;
  logic signed [43:0] s2_dda;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_tdr[i] = 38'((s1_td_r[i] + 53'sd16384) >>> 15);
      s2_ps[i]  = 39'(s2_tdr[i]) + 39'(s1_o_r[i]);
      if (s2_ps[i] < -39'sd1048576) begin
        s2_p[i] = 21'sh100000;
      end else if (s2_ps[i] > 39'sd1048575) begin
        s2_p[i] = 21'sh0FFFFF;
      end else begin
        s2_p[i] = 21'(s2_ps[i]);
      end
    end
    s2_doa = 45'(s1_oca_r[0]) + 45'(s1_oca_r[1]) + 45'(s1_oca_r[2]);
    s2_dda = 44'(s1_da_r[0]) + 44'(s1_da_r[1]) + 44'(s1_da_r[2]);
  end

  logic signed [20:0] s2_p_r  [3];
  logic signed [21:0] s2_pc_r [3];
  logic signed [20:0] s2_a_r  [3];
  logic signed [34:0] s2_doar_r;
  logic signed [33:0] s2_ddar_r;
  logic [30:0]        s2_t_r;
  logic [1:0]         s2_kind_r;
  logic [23:0]        s2_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_p_r[i]  <= s2_p[i];
        s2_pc_r[i] <= 22'(s2_p[i]) - 22'(s1_c_r[i]);
        s2_a_r[i]  <= s1_a_r[i];
      end
      s2_doar_r <= 35'((s2_doa + 45'sd512) >>> 10);
      s2_ddar_r <= 34'((s2_dda + 44'sd512) >>> 10);
      s2_t_r    <= s1_t_r;
      s2_kind_r <= s1_kind_r;
      s2_k_r    <= s1_k_r;
    end
  end

  // stage 3: t * dot(D,A)
  logic signed [65:0] s3_tm_r;
  logic signed [20:0] s3_p_r  [3];
  logic signed [21:0] s3_pc_r [3];
  logic signed [20:0] s3_a_r  [3];
  logic signed [34:0] s3_doar_r;
  logic [1:0]         s3_kind_r;
  logic [23:0]        s3_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tm_r   <= s2_ddar_r * $signed({1'b0, s2_t_r});
      s3_p_r    <= s2_p_r;
      s3_pc_r   <= s2_pc_r;
      s3_a_r    <= s2_a_r;
      s3_doar_r <= s2_doar_r;
      s3_kind_r <= s2_kind_r;
      s3_k_r    <= s2_k_r;
    end
  end

  // stage 4: axial coordinate m, saturated to 32 bits
  logic signed [50:0] s4_tmr;
  logic signed [51:0] s4_ms;
  logic signed [31:0] s4_m;

  always_comb begin
    s4_tmr = 51'((s3_tm_r + 66'sd16384) >>> 15);
    s4_ms  = 52'(s4_tmr) + 52'(s3_doar_r);
    if (s4_ms < -52'sd2147483648) begin
      s4_m = 32'sh80000000;
    end else if (s4_ms > 52'sd2147483647) begin
      s4_m = 32'sh7FFFFFFF;
    end else begin
      s4_m = 32'(s4_ms);
    end
  end

  logic signed [31:0] s4_m_r;
  logic signed [20:0] s4_p_r  [3];
  logic signed [21:0] s4_pc_r [3];
  logic signed [20:0] s4_a_r  [3];
  logic [1:0]         s4_kind_r;
  logic [23:0]        s4_k_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m_r    <= s4_m;
      s4_p_r    <= s3_p_r;
      s4_pc_r   <= s3_pc_r;
      s4_a_r    <= s3_a_r;
      s4_kind_r <= s3_kind_r;
      s4_k_r    <= s3_k_r;
    end
  end

  // stage 5: m * (1 + k^2) for the cone
  logic [24:0] s5_k1;

  assign s5_k1 = 25'(s4_k_r) + 25'd65536;

  logic signed [57:0] s5_mk_r;
  logic signed [31:0] s5_m_r;
  logic signed [20:0] s5_p_r  [3];
  logic signed [21:0] s5_pc_r [3];
  logic signed [20:0] s5_a_r  [3];
  logic [1:0]         s5_kind_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_mk_r   <= s4_m_r * $signed({1'b0, s5_k1});
      s5_m_r    <= s4_m_r;
      s5_p_r    <= s4_p_r;
      s5_pc_r   <= s4_pc_r;
      s5_a_r    <= s4_a_r;
      s5_kind_r <= s4_kind_r;
    end
  end

  // stage 6: round and saturate the cone scaling, pick the effective m
  logic signed [41:0] s6_mkr;
  logic signed [31:0] s6_mc;

  always_comb begin
    s6_mkr = 42'((s5_mk_r + 58'sd32768) >>> 16);
    if (s6_mkr < -42'sd2147483648) begin
      s6_mc = 32'sh80000000;
    end else if (s6_mkr > 42'sd2147483647) begin
      s6_mc = 32'sh7FFFFFFF;
    end else begin
      s6_mc = 32'(s6_mkr);
    end
  end

  logic signed [31:0] s6_m_r;
  logic signed [20:0] s6_p_r  [3];
  logic signed [21:0] s6_pc_r [3];
  logic signed [20:0] s6_a_r  [3];
  logic [1:0]         s6_kind_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_m_r    <= (s5_kind_r == rhsn_pkg::KIND_CONE) ? s6_mc : s5_m_r;
      s6_p_r    <= s5_p_r;
      s6_pc_r   <= s5_pc_r;
      s6_a_r    <= s5_a_r;
      s6_kind_r <= s5_kind_r;
    end
  end

  // stage 7: m * A
  logic signed [52:0] s7_ma_r [3];
  logic signed [20:0] s7_p_r  [3];
  logic signed [21:0] s7_pc_r [3];
  logic signed [20:0] s7_a_r  [3];
  logic [1:0]         s7_kind_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s7_ma_r[i] <= s6_m_r * s6_a_r[i];
      end
      s7_p_r    <= s6_p_r;
      s7_pc_r   <= s6_pc_r;
      s7_a_r    <= s6_a_r;
      s7_kind_r <= s6_kind_r;
    end
  end

  // stage 8: vector to normalise, magnitudes and signs; plane normal
  logic               s8_axial;
  logic signed [53:0] s8_r   [3];
  logic [53:0]        s8_mag [3];
  logic signed [24:0] s8_a16 [3];
  rhsn_pkg::side_t    s8_sd;

  always_comb begin
    s8_axial = s7_kind_r inside {rhsn_pkg::KIND_CONE, rhsn_pkg::KIND_CYLINDER};
    s8_sd.plane = (s7_kind_r == rhsn_pkg::KIND_PLANE);
    s8_sd.zero  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s8_axial) begin
        s8_r[i] = (54'(s7_pc_r[i]) <<< 10) - 54'(s7_ma_r[i]);
      end else begin
        s8_r[i] = 54'(s7_pc_r[i]);
      end
      s8_mag[i] = s8_r[i][53] ? 54'(-s8_r[i]) : 54'(s8_r[i]);
      s8_sd.sgn[i] = s8_r[i][53];
      s8_sd.hit[i] = s7_p_r[i];
      s8_a16[i] = 25'(s7_a_r[i]) <<< 4;
      if (s8_a16[i] > 25'sd16384) begin
        s8_sd.pn[i] = 16'sd16384;
      end else if (s8_a16[i] < -25'sd16384) begin
        s8_sd.pn[i] = -16'sd16384;
      end else begin
        s8_sd.pn[i] = 16'(s8_a16[i]);
      end
    end
  end

  logic [2:0][53:0] s8_mag_r;
  rhsn_pkg::side_t  s8_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_mag_r[i] <= s8_mag[i];
      end
      s8_sd_r <= s8_sd;
    end
  end

  // stage 9: largest magnitude
  logic [53:0] s9_m01;

  assign s9_m01 = (s8_mag_r[1] > s8_mag_r[0]) ? s8_mag_r[1] : s8_mag_r[0];

  logic [53:0]      s9_mx_r;
  logic [2:0][53:0] s9_mag_r;
  rhsn_pkg::side_t  s9_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_mx_r  <= (s8_mag_r[2] > s9_m01) ? s8_mag_r[2] : s9_m01;
      s9_mag_r <= s8_mag_r;
      s9_sd_r  <= s8_sd_r;
    end
  end

  // stage 10: leading one search, first level over nine bit groups
  rhsn_pkg::side_t s10_sd;

  always_comb begin
    s10_sd      = s9_sd_r;
    s10_sd.zero = (s9_mx_r == '0);
  end

  logic [5:0]      s10_nz_r;
  logic [5:0][3:0] s10_loc_r;
  logic [2:0][53:0] s10_mag_r;
  rhsn_pkg::side_t s10_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 6; g++) begin
        s10_nz_r[g]  <= |s9_mx_r[9*g +: 9];
        s10_loc_r[g] <= rhsn_pkg::msb9(s9_mx_r[9*g +: 9]);
      end
      s10_mag_r <= s9_mag_r;
      s10_sd_r  <= s10_sd;
    end
  end

  // stage 11: leading one position and shift that lands it on bit 29
  logic [5:0] s11_pos;
  logic       s11_rsh;

  always_comb begin
    s11_pos = '0;
    for (int g = 0; g < 6; g++) begin
      if (s10_nz_r[g]) begin
        s11_pos = 6'(g * 9) + 6'(s10_loc_r[g]);
      end
    end
    s11_rsh = (s11_pos > 6'd29);
  end

  logic             s11_rsh_r;
  logic [5:0]       s11_amt_r;
  logic [2:0][53:0] s11_mag_r;
  rhsn_pkg::side_t  s11_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_rsh_r <= s11_rsh;
      s11_amt_r <= s11_rsh ? (s11_pos - 6'd29) : (6'd29 - s11_pos);
      s11_mag_r <= s10_mag_r;
      s11_sd_r  <= s10_sd_r;
    end
  end

  // stage 12: shift all magnitudes together, right shifts truncate
  logic [2:0][29:0] s12_nm_r;
  rhsn_pkg::side_t  s12_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s12_nm_r[i] <= s11_rsh_r ? 30'(s11_mag_r[i] >> s11_amt_r)
                                 : 30'(s11_mag_r[i] << s11_amt_r);
      end
      s12_sd_r <= s11_sd_r;
    end
  end

  // stage 13: squares
  logic [2:0][59:0] s13_sq_r;
  logic [2:0][29:0] s13_nm_r;
  rhsn_pkg::side_t  s13_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s13_sq_r[i] <= s12_nm_r[i] * s12_nm_r[i];
      end
      s13_nm_r <= s12_nm_r;
      s13_sd_r <= s12_sd_r;
    end
  end

  // stage 14: sum of squares
  logic [61:0]      s14_sum_r;
  logic [2:0][29:0] s14_nm_r;
  rhsn_pkg::side_t  s14_sd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s14_sum_r <= 62'(s13_sq_r[0]) + 62'(s13_sq_r[1]) + 62'(s13_sq_r[2]);
      s14_nm_r  <= s13_nm_r;
      s14_sd_r  <= s13_sd_r;
    end
  end

  // square root, two root bits per stage
  rhsn_pkg::sq_t    sq_r   [NSQ];
  logic [63:0]      sqx_r  [NSQ];
  logic [2:0][29:0] sqn_r  [NSQ];
  rhsn_pkg::side_t  sqsd_r [NSQ];

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    rhsn_pkg::sq_t    st_in;
    rhsn_pkg::sq_t    st_mid;
    rhsn_pkg::sq_t    st_out;
    logic [63:0]      x_in;
    logic [2:0][29:0] nm_in;
    rhsn_pkg::side_t  sd_in;

    if (g == 0) begin : g_first
      assign st_in = '0;
      assign x_in  = {2'b00, s14_sum_r};
      assign nm_in = s14_nm_r;
      assign sd_in = s14_sd_r;
    end else begin : g_next
      assign st_in = sq_r[g-1];
      assign x_in  = sqx_r[g-1];
      assign nm_in = sqn_r[g-1];
      assign sd_in = sqsd_r[g-1];
    end

    always_comb begin
      st_mid = rhsn_pkg::sqrt_step(st_in, x_in[63-4*g -: 2]);
      st_out = rhsn_pkg::sqrt_step(st_mid, x_in[61-4*g -: 2]);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[g]   <= st_out;
        sqx_r[g]  <= x_in;
        sqn_r[g]  <= nm_in;
        sqsd_r[g] <= sd_in;
      end
    end
  end

  // rounded quotient (mag*2^15 + L) / (2L), two quotient bits per stage
  logic [2:0][47:0] dvr_r  [NDV];
  logic [2:0][15:0] dvq_r  [NDV];
  logic [31:0]      dvd_r  [NDV];
  rhsn_pkg::side_t  dvsd_r [NDV];

  for (genvar g = 0; g < NDV; g++) begin : g_dv
    localparam int HI = 15 - 2 * g;
    localparam int LO = 14 - 2 * g;

    logic [2:0][47:0] rem_in;
    logic [2:0][15:0] q_in;
    logic [31:0]      d_in;
    rhsn_pkg::side_t  sd_in;
    logic [2:0][47:0] rem_out;
    logic [2:0][15:0] q_out;

    if (g == 0) begin : g_first
      logic [31:0] len;
      assign len  = sq_r[NSQ-1].root;
      assign d_in = {len[30:0], 1'b0};
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = 48'({sqn_r[NSQ-1][i], 15'b0}) + 48'(len);
      end
      assign q_in  = '0;
      assign sd_in = sqsd_r[NSQ-1];
    end else begin : g_next
      assign rem_in = dvr_r[g-1];
      assign q_in   = dvq_r[g-1];
      assign d_in   = dvd_r[g-1];
      assign sd_in  = dvsd_r[g-1];
    end

    always_comb begin
      rem_out = rem_in;
      q_out   = q_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_out[i] >= (48'(d_in) << HI)) begin
          rem_out[i] = rem_out[i] - (48'(d_in) << HI);
          q_out[i][HI] = 1'b1;
        end
        if (rem_out[i] >= (48'(d_in) << LO)) begin
          rem_out[i] = rem_out[i] - (48'(d_in) << LO);
          q_out[i][LO] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvr_r[g]  <= rem_out;
        dvq_r[g]  <= q_out;
        dvd_r[g]  <= d_in;
        dvsd_r[g] <= sd_in;
      end
    end
  end

  // output register
  rhsn_pkg::side_t  fin_sd;
  logic [2:0][15:0] fin_n;

  always_comb begin
    fin_sd = dvsd_r[NDV-1];
    for (int i = 0; i < 3; i++) begin
      if (fin_sd.plane) begin
        fin_n[i] = fin_sd.pn[i];
      end else if (fin_sd.zero) begin
        fin_n[i] = '0;
      end else if (fin_sd.sgn[i]) begin
        fin_n[i] = -dvq_r[NDV-1][i];
      end else begin
        fin_n[i] = dvq_r[NDV-1][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_normal_x   <= fin_n[0];
      out_normal_y   <= fin_n[1];
      out_normal_z   <= fin_n[2];
      out_hit_x      <= fin_sd.hit[0];
      out_hit_y      <= fin_sd.hit[1];
      out_hit_z      <= fin_sd.hit[2];
      out_degenerate <= !fin_sd.plane && fin_sd.zero;
    end
  end

endmodule

/* rtl/core/rhsn_checker.sv */
// port level checks for the surface normal core, bound to the top level
module rhsn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic signed [15:0] out_normal_z,
  input logic signed [20:0] out_hit_x,
  input logic signed [20:0] out_hit_y,
  input logic signed [20:0] out_hit_z,
  input logic               out_degenerate
);

  // the input side only holds off while a finished result is stalled
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a stalled output");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == 16'sd0 && out_normal_y == 16'sd0 && out_normal_z == 16'sd0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384 &&
      out_normal_y <= 16'sd16384 && out_normal_y >= -16'sd16384 &&
      out_normal_z <= 16'sd16384 && out_normal_z >= -16'sd16384)
    else $error("normal component out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_normal_x) && $stable(out_normal_y) &&
      $stable(out_normal_z) && $stable(out_hit_x) && $stable(out_hit_y) &&
      $stable(out_hit_z) && $stable(out_degenerate))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind ray_hit_surface_normal_core rhsn_checker u_rhsn_checker (.*);
